// ===== design/atl_pkg.sv =====
// Shared constants, types and the CORDIC angle table of the tilt-angle unit.
package atl_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 8;

  localparam int FIELD_W   = 16;
  localparam int SQ_W      = 32;               // a*a + b*b
  localparam int RAD_W     = SQ_W + 16;        // radicand, sum << 16
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int CW        = 28;               // CORDIC x and y
  localparam int ANG_W     = 32;               // degrees, 24 fraction bits
  localparam int ACC_W     = 24;               // degrees, 16 fraction bits
  localparam int WEIGHT_W  = 16;
  localparam int PROD_W    = WEIGHT_W + 1 + ACC_W + 1;
  localparam int RAW_SH    = 24 - ANGLE_FRAC_BITS;
  localparam int SMOOTH_SH = 16 - ANGLE_FRAC_BITS;

  localparam int STEP_W    = $clog2(CORDIC_STEPS);
  localparam int SQRT_CW   = $clog2(ROOT_W);
  localparam int CNT_W     = (STEP_W > SQRT_CW) ? STEP_W : SQRT_CW;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd3932;
  localparam logic [63:0] DEG_PER_RAD_Q24 = 64'd961263669;

  typedef logic signed [ANG_W-1:0] atan_lut_t [CORDIC_STEPS];

  typedef struct packed {
    logic              load;
    logic              sel;        // 0 roll, 1 pitch
    logic              sq_first;
    logic              sq_second;
    logic              sqrt_step;
    logic              cordic_init;
    logic              cordic_step;
    logic [STEP_W-1:0] step;
    logic              lpf_mul;
    logic              lpf_add;
    logic              publish;
  } atl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } atl_status_t;

  // Restoring long division, elaboration use only.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], num[k]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[k] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in degrees, Q.24, from the alternating series at Q.60.
  function automatic logic signed [ANG_W-1:0] atan_deg(int i);
    logic signed [63:0] sum;
    logic signed [63:0] term;
    logic signed [63:0] rad32;
    logic signed [63:0] prod;
    int sh;
    sum = '0;
    if (i == 0) begin
      return ANG_W'(45 * (1 << 24));
    end
    for (int n = 1; n < 64; n += 2) begin
      sh = i * n;
      if (sh <= 60) begin
        term = $signed(udiv64(64'h1000_0000_0000_0000 >> sh, 64'(n)));
        if (((n >> 1) & 1) != 0) sum = sum - term;
        else                      sum = sum + term;
      end
    end
    rad32 = (sum + 64'sd134217728) >>> 28;
    prod  = rad32 * $signed(DEG_PER_RAD_Q24);
    prod  = (prod + 64'sd2147483648) >>> 32;
    return prod[ANG_W-1:0];
  endfunction

  function automatic atan_lut_t build_atan_lut();
    atan_lut_t t;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      t[i] = atan_deg(i);
    end
    return t;
  endfunction

  localparam atan_lut_t ATAN_LUT = build_atan_lut();

  function automatic logic signed [FIELD_W-1:0] sat16(logic signed [ANG_W-1:0] v);
    if (v > 32'sd32767)       return 16'sh7FFF;
    else if (v < -32'sd32768) return 16'sh8000;
    else                      return v[FIELD_W-1:0];
  endfunction

endpackage

// ===== design/atl_sample_if.sv =====
// Input sample channel: one beat carries one three-axis accelerometer sample.
interface atl_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [atl_pkg::FIELD_W-1:0]    accel_x;
  logic signed [atl_pkg::FIELD_W-1:0]    accel_y;
  logic signed [atl_pkg::FIELD_W-1:0]    accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

// ===== design/atl_result_if.sv =====
// Result channel: one beat carries raw and smoothed roll and pitch.
interface atl_result_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [atl_pkg::FIELD_W-1:0]    roll_raw;
  logic signed [atl_pkg::FIELD_W-1:0]    pitch_raw;
  logic signed [atl_pkg::FIELD_W-1:0]    roll_smooth;
  logic signed [atl_pkg::FIELD_W-1:0]    pitch_smooth;

  modport source (output valid, roll_raw, pitch_raw, roll_smooth, pitch_smooth,
                  input ready);
  modport sink   (input valid, roll_raw, pitch_raw, roll_smooth, pitch_smooth,
                  output ready);
endinterface

// ===== design/atl_ctrl.sv =====
// Sequencer of the tilt-angle unit: steps both angles through the datapath.
module atl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  atl_pkg::atl_status_t  status_i,
  output atl_pkg::atl_cmd_t     cmd_o
);
  import atl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_A, ST_SQ_B, ST_SQRT, ST_C_INIT, ST_CORDIC,
    ST_LPF_MUL, ST_LPF_ADD, ST_PUBLISH
  } state_e;

  state_e           state_q;
  logic             sel_q;
  logic [CNT_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SQ_A;
            sel_q   <= 1'b0;
          end
        end
        ST_SQ_A: state_q <= ST_SQ_B;
        ST_SQ_B: begin
          state_q <= ST_SQRT;
          cnt_q   <= '0;
        end
        ST_SQRT: begin
          if (cnt_q == CNT_W'(ROOT_W - 1)) begin
            state_q <= ST_C_INIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_C_INIT: begin
          state_q <= ST_CORDIC;
          cnt_q   <= '0;
        end
        ST_CORDIC: begin
          if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) begin
            state_q <= ST_LPF_MUL;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_LPF_MUL: state_q <= ST_LPF_ADD;
        ST_LPF_ADD: begin
          if (!sel_q) begin
            sel_q   <= 1'b1;
            state_q <= ST_SQ_A;
          end else begin
            state_q <= ST_PUBLISH;
          end
        end
        ST_PUBLISH: begin
          if (!status_i.out_busy) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o             = '0;
    cmd_o.sel         = sel_q;
    cmd_o.step        = cnt_q[STEP_W-1:0];
    cmd_o.load        = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.sq_first    = (state_q == ST_SQ_A);
    cmd_o.sq_second   = (state_q == ST_SQ_B);
    cmd_o.sqrt_step   = (state_q == ST_SQRT);
    cmd_o.cordic_init = (state_q == ST_C_INIT);
    cmd_o.cordic_step = (state_q == ST_CORDIC);
    cmd_o.lpf_mul     = (state_q == ST_LPF_MUL);
    cmd_o.lpf_add     = (state_q == ST_LPF_ADD);
    cmd_o.publish     = (state_q == ST_PUBLISH) && !status_i.out_busy;
  end

endmodule

// ===== design/atl_datapath.sv =====
// Datapath: squares, bit-serial root, CORDIC vectoring, low-pass and result register.
module atl_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  atl_pkg::atl_cmd_t                   cmd_i,
  output atl_pkg::atl_status_t                status_o,
  input  logic                                cfg_we_i,
  input  logic [atl_pkg::WEIGHT_W-1:0]        cfg_wdata_i,
  input  logic signed [atl_pkg::FIELD_W-1:0]  accel_x_i,
  input  logic signed [atl_pkg::FIELD_W-1:0]  accel_y_i,
  input  logic signed [atl_pkg::FIELD_W-1:0]  accel_z_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [atl_pkg::FIELD_W-1:0]  roll_raw_o,
  output logic signed [atl_pkg::FIELD_W-1:0]  pitch_raw_o,
  output logic signed [atl_pkg::FIELD_W-1:0]  roll_smooth_o,
  output logic signed [atl_pkg::FIELD_W-1:0]  pitch_smooth_o
);
  import atl_pkg::*;

  logic [WEIGHT_W-1:0]        weight_q;
  logic signed [FIELD_W-1:0]  x_q, y_q, z_q;
  logic [SQ_W-1:0]            sq_q;
  logic [RAD_W-1:0]           rad_q;
  logic [ROOT_W-1:0]          root_q;
  logic [REM_W-1:0]           rem_q;
  logic signed [CW-1:0]       cx_q, cy_q;
  logic signed [ANG_W-1:0]    ang_q;
  logic                       zero_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    roll_acc_q, pitch_acc_q;
  logic signed [FIELD_W-1:0]  roll_raw_q, pitch_raw_q, roll_sm_q, pitch_sm_q;
  logic                       out_valid_q;

  // Operand selection for the angle in hand.
  logic signed [FIELD_W:0]    num;
  logic signed [FIELD_W-1:0]  op_a, op_b, mul_op;
  logic signed [SQ_W-1:0]     square;

  assign num    = cmd_i.sel ? -{x_q[FIELD_W-1], x_q} : {y_q[FIELD_W-1], y_q};
  assign op_a   = cmd_i.sel ? y_q : x_q;
  assign op_b   = z_q;
  assign mul_op = cmd_i.sq_first ? op_a : op_b;
  assign square = mul_op * mul_op;

  // One root digit.
  logic [REM_W-1:0] rem_sh, trial;
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  // One micro-rotation.
  logic signed [CW-1:0]    dx, dy;
  logic signed [ANG_W-1:0] da;
  assign dx = cy_q >>> cmd_i.step;
  assign dy = cx_q >>> cmd_i.step;
  assign da = ATAN_LUT[cmd_i.step];

  // Low-pass update.
  logic signed [ANG_W-1:0] raw_full, raw_out;
  logic signed [ACC_W-1:0] acc_sel, acc_new;
  logic signed [ACC_W:0]   diff;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [ANG_W-1:0] acc_wide, sm_out;

  assign raw_full = (ang_q + ANG_W'(128)) >>> 8;
  assign raw_out  = (ang_q + ANG_W'(1 << (RAW_SH - 1))) >>> RAW_SH;
  assign acc_sel  = cmd_i.sel ? pitch_acc_q : roll_acc_q;
  assign diff     = {raw_full[ACC_W-1], raw_full[ACC_W-1:0]} - {acc_sel[ACC_W-1], acc_sel};
  assign prod_rnd = (prod_q + PROD_W'(1 << 15)) >>> 16;
  assign acc_new  = acc_sel + prod_rnd[ACC_W-1:0];
  assign acc_wide = {{(ANG_W-ACC_W){acc_new[ACC_W-1]}}, acc_new};
  assign sm_out   = (acc_wide + ANG_W'(1 << (SMOOTH_SH - 1))) >>> SMOOTH_SH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q    <= WEIGHT_RESET;
      roll_acc_q  <= '0;
      pitch_acc_q <= '0;
      out_valid_q <= 1'b0;
      zero_q      <= 1'b0;
      ang_q       <= '0;
    end else begin
      if (cfg_we_i) weight_q <= cfg_wdata_i;
      if (cmd_i.cordic_init) begin
        ang_q  <= '0;
        zero_q <= (root_q == '0) && (num == '0);
      end else if (cmd_i.cordic_step && !zero_q) begin
        if (cy_q >= 0) ang_q <= ang_q + da;
        else           ang_q <= ang_q - da;
      end
      if (cmd_i.lpf_add) begin
        if (cmd_i.sel) pitch_acc_q <= acc_new;
        else           roll_acc_q  <= acc_new;
      end
      if (cmd_i.publish)              out_valid_q <= 1'b1;
      else if (out_ready_i)           out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= accel_x_i;
      y_q <= accel_y_i;
      z_q <= accel_z_i;
    end
    if (cmd_i.sq_first) sq_q <= $unsigned(square);
    if (cmd_i.sq_second) begin
      rad_q  <= {sq_q + $unsigned(square), 16'b0};
      root_q <= '0;
      rem_q  <= '0;
    end
    if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd_i.cordic_init) begin
      cx_q <= $signed({{(CW-ROOT_W){1'b0}}, root_q});
      cy_q <= {{(CW-FIELD_W-9){num[FIELD_W]}}, num, 8'b0};
    end else if (cmd_i.cordic_step) begin
      if (cy_q >= 0) begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
      end else begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
      end
    end
    if (cmd_i.lpf_mul) begin
      prod_q <= PROD_W'($signed({1'b0, weight_q}) * diff);
      if (cmd_i.sel) pitch_raw_q <= sat16(raw_out);
      else           roll_raw_q  <= sat16(raw_out);
    end
    if (cmd_i.lpf_add) begin
      if (cmd_i.sel) pitch_sm_q <= sat16(sm_out);
      else           roll_sm_q  <= sat16(sm_out);
    end
    if (cmd_i.publish) begin
      roll_raw_o     <= roll_raw_q;
      pitch_raw_o    <= pitch_raw_q;
      roll_smooth_o  <= roll_sm_q;
      pitch_smooth_o <= pitch_sm_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

`ifndef ASSERT_OFF
  a_publish_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |=> out_valid_q) else $error("result not presented after publish");
  a_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    zero_q |-> ang_q == '0) else $error("angle moved for a zero vector");
  a_root_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sq_second |=> (root_q == '0) && (rem_q == '0))
    else $error("root not cleared before extraction");
`endif

endmodule

// ===== design/accel_tilt_angle_lpf_unit.sv =====
// Top level of the accelerometer tilt-angle unit with low-pass smoothing.
// One sample beat (signed x, y, z) yields one result beat: roll =
// atan2(y, sqrt(x*x+z*z)) and pitch = atan2(-x, sqrt(y*y+z*z)) in signed Q7.8
// degrees, raw and smoothed by a first-order low-pass whose Q0.16 weight is
// written on cfg_we_i/cfg_wdata_i (reset 3932, about 0.06). After acceptance the
// two angles go one after the other through a shared datapath, each passing
// through a squaring step for each operand on one multiplier, a 24-bit
// bit-serial square root, a CORDIC load step, 16 CORDIC micro-rotations and
// the low-pass multiply and add steps; a publish step then ends the sample.
// The sequencer then returns to idle before it can take the next beat, so no
// new sample is accepted before the last one has been published. A new
// sample is taken when the sequencer is idle; a finished result waits in the
// output register while the next sample is already being worked on, and the
// publish step holds only if that register is still occupied.
module accel_tilt_angle_lpf_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  atl_sample_if.sink                    sample_i,
  atl_result_if.source                  result_o,
  input  logic                          cfg_we_i,
  input  logic [atl_pkg::WEIGHT_W-1:0]  cfg_wdata_i
);
  import atl_pkg::*;

  atl_cmd_t    cmd;
  atl_status_t status;
  logic        in_ready;

  // Sequencer: owns the input handshake and paces the datapath.
  atl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  assign sample_i.ready = in_ready;

  // Datapath: holds the weight, the filter state and the result register.
  atl_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .accel_x_i      (sample_i.accel_x),
    .accel_y_i      (sample_i.accel_y),
    .accel_z_i      (sample_i.accel_z),
    .out_valid_o    (result_o.valid),
    .out_ready_i    (result_o.ready),
    .roll_raw_o     (result_o.roll_raw),
    .pitch_raw_o    (result_o.pitch_raw),
    .roll_smooth_o  (result_o.roll_smooth),
    .pitch_smooth_o (result_o.pitch_smooth)
  );

endmodule

// ===== test/atl_tilt_checker.sv =====
// Checker for the tilt-angle unit: predicts each result beat and compares it.
`timescale 1ns / 1ps

module atl_tilt_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  atl_sample_if       smp,
  atl_result_if       res,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          seen_o
);

  typedef struct {
    logic signed [15:0] roll_raw;
    logic signed [15:0] pitch_raw;
    logic signed [15:0] roll_smooth;
    logic signed [15:0] pitch_smooth;
  } tilt_beat_t;

  tilt_beat_t  tilt_q[$];
  longint      atan_deg_rom [16];
  logic [15:0] weight;
  longint      roll_keep;
  longint      pitch_keep;

  function automatic longint round_shr(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint atan_step_deg(int i);
    longint sum;
    longint term;
    longint rad;
    sum = 0;
    if (i == 0) return longint'(45) << 24;
    for (int n = 1; n < 64; n += 2) begin
      if (i * n > 60) break;
      term = (longint'(1) << (60 - i * n)) / n;
      sum = ((n >> 1) & 1) ? sum - term : sum + term;
    end
    rad = round_shr(sum, 28);
    return round_shr(rad * 64'sd961263669, 32);
  endfunction

  function automatic longint int_root(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  // atan2(num, sqrt(a*a + b*b)) in degrees with 24 fraction bits
  function automatic longint tilt_deg(longint num, longint a, longint b);
    longint xv;
    longint yv;
    longint ang;
    longint dx;
    longint dy;
    xv  = int_root(longint'(a * a + b * b) << 16);
    yv  = num * 256;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    for (int i = 0; i < 16; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv += dx; yv -= dy; ang += atan_deg_rom[i];
      end else begin
        xv -= dx; yv += dy; ang -= atan_deg_rom[i];
      end
    end
    return ang;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint smooth_step(longint keep, longint raw16);
    return keep + round_shr(longint'(weight) * (raw16 - keep), 16);
  endfunction

  task automatic predict_tilt(longint x, longint y, longint z);
    longint     roll24;
    longint     pitch24;
    tilt_beat_t b;
    roll24     = tilt_deg(y, x, z);
    pitch24    = tilt_deg(-x, y, z);
    roll_keep  = smooth_step(roll_keep, round_shr(roll24, 8));
    pitch_keep = smooth_step(pitch_keep, round_shr(pitch24, 8));
    b.roll_raw     = clip16(round_shr(roll24, 16));
    b.pitch_raw    = clip16(round_shr(pitch24, 16));
    b.roll_smooth  = clip16(round_shr(roll_keep, 8));
    b.pitch_smooth = clip16(round_shr(pitch_keep, 8));
    tilt_q.push_back(b);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    fail_cnt_o++;
  endtask

  initial begin
    fail_cnt_o = 0;
    seen_o = 0;
    for (int i = 0; i < 16; i++) atan_deg_rom[i] = atan_step_deg(i);
  end

  assign pending_o = tilt_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    tilt_beat_t w;
    if (!rst_ni) begin
      weight     = 16'd3932;
      roll_keep  = 0;
      pitch_keep = 0;
      tilt_q.delete();
    end else begin
      if (cfg_we_i) weight = cfg_wdata_i;
      if (smp.valid && smp.ready) predict_tilt(smp.accel_x, smp.accel_y, smp.accel_z);
      if (res.valid && res.ready) begin
        seen_o++;
        if (tilt_q.size() == 0) begin
          report_mismatch("result beat with nothing expected", 1, 0);
        end else begin
          w = tilt_q.pop_front();
          if (res.roll_raw !== w.roll_raw)
            report_mismatch("roll_raw", res.roll_raw, w.roll_raw);
          if (res.pitch_raw !== w.pitch_raw)
            report_mismatch("pitch_raw", res.pitch_raw, w.pitch_raw);
          if (res.roll_smooth !== w.roll_smooth)
            report_mismatch("roll_smooth", res.roll_smooth, w.roll_smooth);
          if (res.pitch_smooth !== w.pitch_smooth)
            report_mismatch("pitch_smooth", res.pitch_smooth, w.pitch_smooth);
        end
      end
    end
  end

endmodule

// ===== test/accel_tilt_angle_lpf_unit_test.sv =====
// Testbench top: drives samples and weights into the tilt-angle unit and gives the verdict.
`timescale 1ns / 1ps

module accel_tilt_angle_lpf_unit_test;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          fail_cnt;
  int          pending;
  int          seen;
  int          idle_pct;
  int          stall_pct;
  bit          hold_off;
  longint      cycles;
  int          sent;

  atl_sample_if smp_if ();
  atl_result_if res_if ();

  accel_tilt_angle_lpf_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .sample_i    (smp_if),
    .result_o    (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  atl_tilt_checker u_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .smp         (smp_if),
    .res         (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .seen_o      (seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off entirely while the pressure test runs.
  always @(negedge clk) begin
    if (!rst_n || hold_off) res_if.ready <= 1'b0;
    else res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one beat, idling first at random; return at the falling edge after acceptance.
  task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < idle_pct) begin
      smp_if.valid = 1'b0;
      @(negedge clk);
    end
    smp_if.valid   = 1'b1;
    smp_if.accel_x = x;
    smp_if.accel_y = y;
    smp_if.accel_z = z;
    do @(posedge clk); while (!smp_if.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_random_sample();
    logic [15:0] a [3];
    int          kind;
    int          g;
    kind = $urandom_range(9);
    for (int k = 0; k < 3; k++) begin
      case (kind)
        0, 1, 2, 3: a[k] = 16'($urandom);
        4, 5:       a[k] = 16'($signed($urandom_range(64)) - 32);
        default:    a[k] = 16'($signed($urandom_range(800)) - 400);
      endcase
    end
    // Gravity along one axis, mostly: the everyday sensor picture.
    if (kind >= 6) begin
      g = $urandom_range(2);
      a[g] = $urandom_range(1) ? 16'(16384 + $urandom_range(2000))
                               : 16'(-16384 - int'($urandom_range(2000)));
    end
    if (kind == 9) a[$urandom_range(2)] = 16'd0;
    send_sample(a[0], a[1], a[2]);
  endtask

  // Drain every expected beat, then let the datapath go quiet before a write.
  task automatic settle();
    smp_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_weight(logic [15:0] w);
    cfg_we    = 1'b1;
    cfg_wdata = w;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  logic [15:0] weights [5] = '{16'd3932, 16'd0, 16'd65535, 16'd1, 16'd0};
  int          idles   [4] = '{0, 84, 0, 84};
  int          stalls  [4] = '{0, 0, 84, 84};

  initial begin
    smp_if.valid   = 1'b0;
    smp_if.accel_x = '0;
    smp_if.accel_y = '0;
    smp_if.accel_z = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    hold_off  = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    sent      = 0;
    rst_n     = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // Directed: reset weight, field extremes, both atan arguments zero, root zero.
    send_sample(16'sh0000, 16'sh0000, 16'sh0000);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF, 16'sh0000);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh0000);
    send_sample(16'sh0000, 16'sh0000, 16'sh4000);
    send_sample(16'sh0000, 16'sh0000, 16'sh8000);
    send_sample(16'sh0000, 16'sh4000, 16'sh0000);
    send_sample(16'sh0000, 16'shC000, 16'sh0000);
    send_sample(16'sh4000, 16'sh0000, 16'sh0000);
    send_sample(16'shC000, 16'sh0000, 16'sh0000);
    send_sample(16'sh0001, 16'shFFFF, 16'sh0000);
    send_sample(16'shFFFF, 16'sh0001, 16'sh0001);
    send_sample(16'sh5555, 16'shAAAA, 16'sh5555);
    send_sample(16'shAAAA, 16'sh5555, 16'shAAAA);
    settle();
    // Full weight, then a frozen filter, on a few hand-picked beats.
    write_weight(16'hFFFF);
    send_sample(16'sh2000, 16'sh1000, 16'sh3000);
    send_sample(16'shE000, 16'shF000, 16'sh3000);
    settle();
    write_weight(16'h0000);
    send_sample(16'sh1000, 16'sh7000, 16'sh0100);
    send_sample(16'sh0000, 16'sh0000, 16'sh0000);
    settle();

    // Random phases, each under a different weight and idling pattern.
    for (int ph = 0; ph < 5; ph++) begin
      write_weight(ph == 4 ? 16'($urandom) : weights[ph]);
      idle_pct  = ph < 4 ? idles[ph] : 8;
      stall_pct = ph < 4 ? stalls[ph] : 8;
      for (int n = 0; n < 270; n++) begin
        send_random_sample();
        // Now and then run without any idling for a stretch.
        if (n == 130) begin
          idle_pct = 0;
          stall_pct = 0;
        end else if (n == 170) begin
          idle_pct  = ph < 4 ? idles[ph] : 8;
          stall_pct = ph < 4 ? stalls[ph] : 8;
        end
      end
      settle();
    end

    // Pressure: the receiver holds off long while samples keep coming.
    write_weight(16'd3932);
    idle_pct  = 0;
    stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int n = 0; n < 12; n++) send_random_sample();
    join
    // Pause the sender until the unit is fully drained, then resume.
    smp_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    for (int n = 0; n < 20; n++) send_random_sample();
    smp_if.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);

    $display("Sent %0d samples, checked %0d result beats", sent, seen);
    $display("Covered weights 0, 1, reset, full and random under five idling patterns");
    if (fail_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
